/* hw/rtl/cafsb_pkg.sv */
package cafsb_pkg;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_MEM     = 2'd1,
        ST_STACK_FULL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_SCAN,
        S_CALC,
        S_WRITE
    } state_t;

    localparam logic [1:0] CFG_OFFSET   = 2'd0;
    localparam logic [1:0] CFG_RESERVED = 2'd1;
    localparam logic [1:0] CFG_COUNT    = 2'd2;

    localparam int ALIGN_BYTES = 16;
    localparam logic [63:0] ALIGN_LOW = 64'(ALIGN_BYTES - 1);

    typedef struct packed {
        logic [63:0] start;
        logic [63:0] size;
        logic [63:0] cursor;
    } region_t;

    typedef struct packed {
        logic        push;
        logic        pop;
        logic [63:0] data;
    } stack_req_t;

    typedef struct packed {
        logic empty;
        logic full;
    } stack_stat_t;

endpackage

/* hw/rtl/cafsb_free_stack.sv */
module cafsb_free_stack
    import cafsb_pkg::*;
#(
    parameter int FREE_DEPTH = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  stack_req_t  req,
    output stack_stat_t stat,
    output logic [63:0] pop_data
);

    localparam int CW = $clog2(FREE_DEPTH + 1);
    localparam int AW = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;

    logic [63:0]   stack_mem [FREE_DEPTH];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          do_push;
    logic          do_pop;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CW'(FREE_DEPTH));

    assign do_push = req.push && !stat.full;
    assign do_pop  = req.pop && !stat.empty;

    assign wr_addr = AW'(count_reg);
    assign rd_addr = AW'(count_reg - CW'(1));

    always_comb
    begin
        count_next = count_reg;
        if (do_push)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // top of stack sits at count - 1
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            stack_mem[wr_addr] <= req.data;
        end
        if (do_pop)
        begin
            pop_data <= stack_mem[rd_addr];
        end
    end

`ifndef NO_ASSERTIONS
    a_pop_not_empty : assert property (@(posedge clk) disable iff (!rst_n)
        req.pop |-> !stat.empty)
        else $error("pop from empty free stack");

    a_no_push_pop : assert property (@(posedge clk) disable iff (!rst_n)
        !(req.push && req.pop))
        else $error("push and pop in one cycle");

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(FREE_DEPTH))
        else $error("free stack count beyond depth");
`endif

endmodule

/* hw/rtl/chunk_allocator_free_stack_bump.sv */
// latency: load, free and op 3 give their result in the cycle after acceptance, one per cycle
// allocate from the free stack: result two cycles after acceptance, busy for one cycle
// allocate by scan: one region table entry per cycle over the synchronous memory read port,
// result k + 4 cycles after acceptance on a hit at entry k, n + 1 cycles on a miss over n entries
// reset clears config, eligible flags, stack count and control; table and stack data are
// not cleared, so no clearing pass is needed; the receiver cannot stall results
module chunk_allocator_free_stack_bump
    import cafsb_pkg::*;
#(
    parameter int MAX_REGIONS = 16,
    parameter int FREE_DEPTH  = 256,
    parameter int CHUNK_BYTES = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [3:0]  region_index,
    input  logic [63:0] region_base,
    input  logic [63:0] region_length,
    input  logic        region_usable,
    input  logic [63:0] free_address,

    output logic        done,
    output logic [63:0] chunk_address,
    output logic [1:0]  status,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int NW    = ($clog2(MAX_REGIONS + 1) > 5) ? $clog2(MAX_REGIONS + 1) : 5;

    // configuration
    logic [63:0] address_offset_reg;
    logic [15:0] reserved_bytes_reg;
    logic [4:0]  region_count_reg;

    // control
    state_t                 state_reg;
    state_t                 state_next;
    logic [MAX_REGIONS-1:0] elig_reg;
    logic [MAX_REGIONS-1:0] elig_next;
    logic [IDX_W-1:0]       scan_idx_reg;
    logic [IDX_W-1:0]       scan_idx_next;
    logic                   first_seen_reg;
    logic                   first_seen_next;
    logic                   done_reg;
    logic                   done_next;

    // payload
    region_t          hit_entry_reg;
    region_t          hit_entry_next;
    logic [15:0]      hit_meta_reg;
    logic [15:0]      hit_meta_next;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [IDX_W-1:0] hit_idx_next;
    logic [63:0]      area_reg;
    logic [63:0]      area_next;
    logic [63:0]      pos_reg;
    logic [63:0]      pos_next;
    logic [63:0]      chunk_address_reg;
    logic [63:0]      chunk_address_next;
    status_t          status_reg;
    status_t          status_next;

    // region table memory
    region_t          region_mem [MAX_REGIONS];
    region_t          rmem_rdata;
    region_t          rmem_wdata;
    logic [IDX_W-1:0] rmem_waddr;
    logic [IDX_W-1:0] rmem_raddr;
    logic             rmem_we;

    // free stack
    stack_req_t  stack_req;
    stack_stat_t stack_stat;
    logic [63:0] stack_pop_data;

    logic          accept;
    logic [NW-1:0] count_ext;
    logic [NW-1:0] n_full;
    logic          scan_last;
    logic          load_in_range;
    logic          cur_elig;
    logic [15:0]   meta;
    logic [65:0]   fit_sum;
    logic          fit;

    assign busy          = (state_reg != S_IDLE);
    assign accept        = start && !busy;
    assign cfg_ready     = 1'b1;
    assign done          = done_reg;
    assign chunk_address = chunk_address_reg;
    assign status        = status_reg;

    assign count_ext     = NW'(region_count_reg);
    assign n_full        = (count_ext > NW'(MAX_REGIONS)) ? NW'(MAX_REGIONS) : count_ext;
    assign scan_last     = (NW'(scan_idx_reg) == n_full - NW'(1));
    assign load_in_range = (NW'(region_index) < NW'(MAX_REGIONS));

    // metadata bytes belong to the first eligible region seen in the scan
    assign cur_elig = elig_reg[scan_idx_reg];
    assign meta     = first_seen_reg ? 16'd0 : reserved_bytes_reg;
    assign fit_sum  = {2'b00, rmem_rdata.cursor} + 66'(meta) + 66'(CHUNK_BYTES);
    assign fit      = cur_elig && (fit_sum < {2'b00, rmem_rdata.size});

    cafsb_free_stack #(
        .FREE_DEPTH (FREE_DEPTH)
    ) u_free_stack (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (stack_req),
        .stat     (stack_stat),
        .pop_data (stack_pop_data)
    );

    always_comb
    begin
        state_next         = state_reg;
        elig_next          = elig_reg;
        scan_idx_next      = scan_idx_reg;
        first_seen_next    = first_seen_reg;
        done_next          = 1'b0;
        hit_entry_next     = hit_entry_reg;
        hit_meta_next      = hit_meta_reg;
        hit_idx_next       = hit_idx_reg;
        area_next          = area_reg;
        pos_next           = pos_reg;
        chunk_address_next = chunk_address_reg;
        status_next        = status_reg;
        rmem_we            = 1'b0;
        rmem_waddr         = hit_idx_reg;
        rmem_wdata         = hit_entry_reg;
        rmem_raddr         = '0;
        stack_req.push     = 1'b0;
        stack_req.pop      = 1'b0;
        stack_req.data     = free_address;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    done_next          = 1'b1;
                    chunk_address_next = '0;
                    status_next        = ST_OK;
                    case (op)
                        OP_LOAD:
                        begin
                            if (load_in_range)
                            begin
                                rmem_we           = 1'b1;
                                rmem_waddr        = IDX_W'(region_index);
                                rmem_wdata.start  = region_base + address_offset_reg;
                                rmem_wdata.size   = region_length;
                                rmem_wdata.cursor = '0;
                                elig_next[IDX_W'(region_index)] = region_usable &&
                                    (region_length > 64'(reserved_bytes_reg));
                            end
                        end
                        OP_ALLOC:
                        begin
                            if (!stack_stat.empty)
                            begin
                                stack_req.pop = 1'b1;
                                done_next     = 1'b0;
                                state_next    = S_POP;
                            end
                            else if (n_full == '0)
                            begin
                                status_next = ST_NO_MEM;
                            end
                            else
                            begin
                                // table entry 0 is read at this edge
                                done_next       = 1'b0;
                                scan_idx_next   = '0;
                                first_seen_next = 1'b0;
                                state_next      = S_SCAN;
                            end
                        end
                        OP_FREE:
                        begin
                            if (!stack_stat.full)
                            begin
                                stack_req.push = 1'b1;
                            end
                            else
                            begin
                                status_next = ST_STACK_FULL;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_POP:
            begin
                done_next          = 1'b1;
                chunk_address_next = stack_pop_data;
                status_next        = ST_OK;
                state_next         = S_IDLE;
            end
            S_SCAN:
            begin
                rmem_raddr = scan_idx_reg + IDX_W'(1);
                if (fit)
                begin
                    hit_entry_next = rmem_rdata;
                    hit_meta_next  = meta;
                    hit_idx_next   = scan_idx_reg;
                    state_next     = S_CALC;
                end
                else if (scan_last)
                begin
                    done_next          = 1'b1;
                    chunk_address_next = '0;
                    status_next        = ST_NO_MEM;
                    state_next         = S_IDLE;
                end
                else
                begin
                    scan_idx_next   = scan_idx_reg + IDX_W'(1);
                    first_seen_next = first_seen_reg | cur_elig;
                end
            end
            S_CALC:
            begin
                area_next  = hit_entry_reg.start + 64'(hit_meta_reg);
                pos_next   = (hit_entry_reg.start + 64'(hit_meta_reg) + hit_entry_reg.cursor
                              + ALIGN_LOW) & ~ALIGN_LOW;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                // cursor is kept relative to the chunk area base
                rmem_we            = 1'b1;
                rmem_waddr         = hit_idx_reg;
                rmem_wdata.start   = hit_entry_reg.start;
                rmem_wdata.size    = hit_entry_reg.size;
                rmem_wdata.cursor  = pos_reg + 64'(CHUNK_BYTES) - area_reg;
                done_next          = 1'b1;
                chunk_address_next = pos_reg;
                status_next        = ST_OK;
                state_next         = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            elig_reg       <= '0;
            scan_idx_reg   <= '0;
            first_seen_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            elig_reg       <= elig_next;
            scan_idx_reg   <= scan_idx_next;
            first_seen_reg <= first_seen_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_entry_reg     <= hit_entry_next;
        hit_meta_reg      <= hit_meta_next;
        hit_idx_reg       <= hit_idx_next;
        area_reg          <= area_next;
        pos_reg           <= pos_next;
        chunk_address_reg <= chunk_address_next;
        status_reg        <= status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            address_offset_reg <= '0;
            reserved_bytes_reg <= '0;
            region_count_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_OFFSET:   address_offset_reg <= cfg_data;
                CFG_RESERVED: reserved_bytes_reg <= cfg_data[15:0];
                CFG_COUNT:    region_count_reg   <= cfg_data[4:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (rmem_we)
        begin
            region_mem[rmem_waddr] <= rmem_wdata;
        end
        rmem_rdata <= region_mem[rmem_raddr];
    end

`ifndef NO_ASSERTIONS
    a_no_done_while_busy : assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !done)
        else $error("result word while busy");

    a_write_gives_done : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |=> (done && (status == ST_OK)))
        else $error("cursor write back without ok result");

    a_calc_after_scan : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CALC) |-> $past(state_reg == S_SCAN))
        else $error("bump calc not preceded by scan hit");

    a_fail_zero_addr : assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_OK)) |-> (chunk_address == 64'd0))
        else $error("failed result carries an address");
`endif

endmodule
